// ===== hw/rtl/msmd_pkg.sv =====
// ----------------------------------------------------------------------------
// msmd_pkg
// shared types, constants and key table expansion for the stream unmask block
// ----------------------------------------------------------------------------
package msmd_pkg;

  // byte counter width
  localparam int LENGTH_BITS = 16;
  localparam int POS_BITS    = 16;
  localparam int LEN_BITS    = 16;

  // chunk layout offsets
  localparam logic [LENGTH_BITS-1:0] HEAD_SKIP   = LENGTH_BITS'('h40);
  localparam logic [LENGTH_BITS-1:0] BODY_START  = LENGTH_BITS'('h140);
  localparam logic [LENGTH_BITS-1:0] HOLD_SIZE   = LENGTH_BITS'('h100);
  localparam logic [LENGTH_BITS-1:0] RELEASE_END = LENGTH_BITS'('h240);
  localparam logic [LEN_BITS-1:0]    MIN_VIDEO_LEN = LEN_BITS'('h240);
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX   = {LENGTH_BITS{1'b1}};

  // hold buffer memory
  localparam int HOLD_DEPTH     = 256;
  localparam int HOLD_ADDR_BITS = $clog2(HOLD_DEPTH);

  // key table
  localparam int KEY_BYTES    = 32;
  localparam int KEY_IDX_BITS = $clog2(KEY_BYTES);
  localparam logic [3:0][7:0] AUDIO_TAG = {8'h43, 8'h55, 8'h52, 8'h55};

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH = 1'b1;

  // request operations
  localparam logic [1:0] OP_PASS    = 2'd0;
  localparam logic [1:0] OP_AUDIO   = 2'd1;
  localparam logic [1:0] OP_HOLD    = 2'd2;
  localparam logic [1:0] OP_DECRYPT = 2'd3;

  // queue sizes
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
  localparam int RES_CNT_BITS = RES_PTR_BITS + 1;

  typedef logic [KEY_BYTES-1:0][7:0] key_table_t;

  typedef struct packed {
    logic [7:0]                data;
    logic [POS_BITS-1:0]       pos;
    logic [POS_BITS-1:0]       rel_pos;
    logic [HOLD_ADDR_BITS-1:0] addr;
    logic [KEY_IDX_BITS-1:0]   k;
    logic [1:0]                op;
    logic                      rel;
    logic                      start;
    logic                      fin;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          data;
    logic [POS_BITS-1:0] pos;
    logic                done;
  } res_t;

  typedef struct packed {
    logic                    stage_valid;
    logic [RES_CNT_BITS-1:0] res_count;
  } back_status_t;

  // expand the two key words into the 32-byte key table
  function automatic key_table_t build_key_table(input logic [31:0] lo,
                                                 input logic [31:0] hi);
    logic [7:0] t [KEY_BYTES];
    key_table_t r;
    t[0]  = lo[7:0];
    t[1]  = lo[15:8];
    t[2]  = lo[23:16];
    t[3]  = lo[31:24] - 8'h34;
    t[4]  = hi[7:0] + 8'hF9;
    t[5]  = hi[15:8] ^ 8'h13;
    t[6]  = hi[23:16] + 8'h61;
    t[7]  = t[0] ^ 8'hFF;
    t[8]  = t[2] + t[1];
    t[9]  = t[1] - t[7];
    t[10] = t[2] ^ 8'hFF;
    t[11] = t[1] ^ 8'hFF;
    t[12] = t[11] + t[9];
    t[13] = t[8] - t[3];
    t[14] = t[13] ^ 8'hFF;
    t[15] = t[10] - t[11];
    t[16] = t[8] - t[15];
    t[17] = t[16] ^ t[7];
    t[18] = t[15] ^ 8'hFF;
    t[19] = t[3] ^ 8'h10;
    t[20] = t[4] - 8'h32;
    t[21] = t[5] + 8'hED;
    t[22] = t[6] ^ 8'hF3;
    t[23] = t[19] - t[15];
    t[24] = t[21] + t[7];
    t[25] = 8'h21 - t[19];
    t[26] = t[20] ^ t[23];
    t[27] = t[22] + t[22];
    t[28] = t[23] + 8'h44;
    t[29] = t[3] + t[4];
    t[30] = t[5] - t[22];
    t[31] = t[29] ^ t[19];
    for (int i = 0; i < KEY_BYTES; i++) begin
      r[i] = t[i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/msmd_ram.sv =====
// ----------------------------------------------------------------------------
// msmd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module msmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/msmd_front.sv =====
// ----------------------------------------------------------------------------
// msmd_front
// byte counter and classification of each incoming byte into a request
// ----------------------------------------------------------------------------
module msmd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          q_full,
  input  logic [7:0]                    data_byte,
  input  logic                          stream_kind,
  input  logic [msmd_pkg::LEN_BITS-1:0] payload_length,
  input  logic                          final_byte,
  output logic                          cmd_push,
  output msmd_pkg::cmd_t                cmd
);

  logic [msmd_pkg::LENGTH_BITS-1:0] byte_counter;
  logic [msmd_pkg::LENGTH_BITS-1:0] byte_counter_next;

  assign cmd_push = push && !q_full;

  always_comb begin
    cmd.data    = data_byte;
    cmd.pos     = msmd_pkg::POS_BITS'(byte_counter);
    cmd.rel_pos = msmd_pkg::POS_BITS'(byte_counter - msmd_pkg::HOLD_SIZE);
    // hold write and release read land on the same slot offset
    cmd.addr    = msmd_pkg::HOLD_ADDR_BITS'(byte_counter - msmd_pkg::HEAD_SKIP);
    cmd.k       = byte_counter[msmd_pkg::KEY_IDX_BITS-1:0];
    cmd.start   = (byte_counter == '0);
    cmd.fin     = final_byte;
    cmd.rel     = 1'b0;
    if (stream_kind) begin
      cmd.op = (byte_counter >= msmd_pkg::BODY_START) ? msmd_pkg::OP_AUDIO
                                                       : msmd_pkg::OP_PASS;
    end else if (payload_length < msmd_pkg::MIN_VIDEO_LEN ||
                 byte_counter < msmd_pkg::HEAD_SKIP) begin
      cmd.op = msmd_pkg::OP_PASS;
    end else if (byte_counter < msmd_pkg::BODY_START) begin
      cmd.op = msmd_pkg::OP_HOLD;
    end else begin
      cmd.op  = msmd_pkg::OP_DECRYPT;
      cmd.rel = (byte_counter < msmd_pkg::RELEASE_END);
    end
  end

  // saturating byte offset, cleared after the last byte of a chunk
  always_comb begin
    if (final_byte) begin
      byte_counter_next = '0;
    end else if (byte_counter != msmd_pkg::COUNT_MAX) begin
      byte_counter_next = byte_counter + 1'b1;
    end else begin
      byte_counter_next = byte_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
    end else if (cmd_push) begin
      byte_counter <= byte_counter_next;
    end
  end

endmodule

// ===== hw/rtl/msmd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// msmd_cmd_queue
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module msmd_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  msmd_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output msmd_pkg::cmd_t cmd_out,
  output logic           empty
);

  msmd_pkg::cmd_t                  slots [msmd_pkg::CMD_DEPTH];
  logic [msmd_pkg::CMD_PTR_BITS-1:0] wr_ptr;
  logic [msmd_pkg::CMD_PTR_BITS-1:0] rd_ptr;
  logic [msmd_pkg::CMD_PTR_BITS:0]   count;

  assign full    = (count == (msmd_pkg::CMD_PTR_BITS + 1)'(msmd_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (msmd_pkg::CMD_PTR_BITS + 1)'(push)
                     - (msmd_pkg::CMD_PTR_BITS + 1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/msmd_back.sv =====
// ----------------------------------------------------------------------------
// msmd_back
// key registers, mask state, hold buffer and result queue; carries out requests
// ----------------------------------------------------------------------------
module msmd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [msmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                         cfg_data,
  input  msmd_pkg::cmd_t                      cmd,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  output msmd_pkg::res_t                      res,
  output logic                                res_empty,
  input  logic                                res_pop,
  output msmd_pkg::back_status_t              status
);

  logic [31:0]          key_low_word;
  logic [31:0]          key_high_word;
  msmd_pkg::key_table_t tab;

  logic                 s_valid;
  msmd_pkg::cmd_t       s_cmd;
  logic                 fire;

  logic [7:0] feedback_mask [msmd_pkg::KEY_BYTES];
  logic [7:0] head_mask     [msmd_pkg::KEY_BYTES];
  logic [7:0] hold_rdata;

  logic [7:0] head_k;
  logic [7:0] body_k;
  logic [7:0] aud_k;
  logic [7:0] plain;
  logic [7:0] head_new;

  msmd_pkg::res_t                      r0;
  msmd_pkg::res_t                      r1;
  logic [1:0]                          n_res;
  msmd_pkg::res_t                      res_mem [msmd_pkg::RES_DEPTH];
  logic [msmd_pkg::RES_PTR_BITS-1:0]   res_wr;
  logic [msmd_pkg::RES_PTR_BITS-1:0]   res_rd;
  logic [msmd_pkg::RES_CNT_BITS-1:0]   res_count;
  logic                                res_take;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_word  <= '0;
      key_high_word <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msmd_pkg::REG_KEY_LOW:  key_low_word  <= cfg_data;
        msmd_pkg::REG_KEY_HIGH: key_high_word <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tab <= msmd_pkg::build_key_table(key_low_word, key_high_word);
  end

  // execute stage handshake
  assign fire    = s_valid &&
                   (res_count <= msmd_pkg::RES_CNT_BITS'(msmd_pkg::RES_DEPTH - 2));
  assign cmd_pop = !cmd_empty && (!s_valid || fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd_pop) begin
      s_valid <= 1'b1;
    end else if (fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s_cmd <= cmd;
    end
  end

  // hold buffer: written on held bytes, read when a request leaves the queue
  msmd_ram #(
    .WIDTH (8),
    .DEPTH (msmd_pkg::HOLD_DEPTH)
  ) u_hold (
    .clk   (clk),
    .we    (cmd_pop && cmd.op == msmd_pkg::OP_HOLD),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .re    (cmd_pop),
    .raddr (cmd.addr),
    .rdata (hold_rdata)
  );

  // mask lookups at the byte's slot
  always_comb begin
    head_k   = tab[s_cmd.k];
    body_k   = ~tab[s_cmd.k];
    aud_k    = s_cmd.k[0] ? msmd_pkg::AUDIO_TAG[s_cmd.k[2:1]] : body_k;
    plain    = s_cmd.data ^ feedback_mask[s_cmd.k];
    head_new = head_mask[s_cmd.k] ^ plain;
  end

  always_comb begin
    r0    = '{data: s_cmd.data, pos: s_cmd.pos, done: s_cmd.fin};
    r1    = '{data: plain, pos: s_cmd.pos, done: s_cmd.fin};
    n_res = 2'd1;
    unique case (s_cmd.op)
      msmd_pkg::OP_PASS: begin
        n_res = 2'd1;
      end
      msmd_pkg::OP_AUDIO: begin
        r0.data = s_cmd.data ^ aud_k;
      end
      msmd_pkg::OP_HOLD: begin
        n_res = 2'd0;
      end
      msmd_pkg::OP_DECRYPT: begin
        if (s_cmd.rel) begin
          // released held byte goes ahead of the current one
          r0    = '{data: hold_rdata ^ head_new, pos: s_cmd.rel_pos, done: 1'b0};
          n_res = 2'd2;
        end else begin
          r0.data = plain;
        end
      end
    endcase
  end

  // running masks
  always_ff @(posedge clk) begin
    if (fire) begin
      if (s_cmd.start) begin
        for (int i = 0; i < msmd_pkg::KEY_BYTES; i++) begin
          feedback_mask[i] <= ~tab[i];
          head_mask[i]     <= tab[i];
        end
      end else if (s_cmd.op == msmd_pkg::OP_DECRYPT) begin
        feedback_mask[s_cmd.k] <= plain ^ body_k;
        if (s_cmd.rel) begin
          head_mask[s_cmd.k] <= head_new;
        end
      end
    end
  end

  // result queue, up to two writes per cycle
  assign res_take  = res_pop && (res_count != '0);
  assign res_empty = (res_count == '0);
  assign res       = res_mem[res_rd];

  always_ff @(posedge clk) begin
    if (fire && n_res != 2'd0) begin
      res_mem[res_wr] <= r0;
    end
    if (fire && n_res == 2'd2) begin
      res_mem[res_wr + 1'b1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= '0;
      res_rd    <= '0;
      res_count <= '0;
    end else begin
      if (fire) begin
        res_wr <= res_wr + msmd_pkg::RES_PTR_BITS'(n_res);
      end
      if (res_take) begin
        res_rd <= res_rd + 1'b1;
      end
      res_count <= res_count
                   + (fire ? msmd_pkg::RES_CNT_BITS'(n_res) : '0)
                   - msmd_pkg::RES_CNT_BITS'(res_take);
    end
  end

  assign status = '{stage_valid: s_valid, res_count: res_count};

endmodule

// ===== hw/rtl/movie_stream_mask_decrypt_top.sv =====
// ----------------------------------------------------------------------------
// movie_stream_mask_decrypt_top
// byte-serial unmasking of movie container video and audio chunk payloads
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// input     in         push / full           data_byte, stream_kind,
//                                            payload_length, final_byte
// result    out        empty / pop           plain_byte, byte_position,
//                                            chunk_done
// config    in         cfg_write             cfg_index, cfg_data (32 bit)
//
// one byte is taken per cycle while full is low; a result passes through the
// request queue, the execute stage and the result queue before it shows on the
// ports. bytes 0x140..0x23f of a long video chunk give two results each, so
// there the result port sets the pace. reset is synchronous, with no clearing
// pass: the hold buffer is always written before it is read within a chunk.
// a stalled result port fills the result queue, then the execute stage, then
// the request queue, and only then raises full.
//
module movie_stream_mask_decrypt_top (
  input  logic                                clk,
  input  logic                                rst,
  // byte input
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          data_byte,
  input  logic                                stream_kind,
  input  logic [msmd_pkg::LEN_BITS-1:0]       payload_length,
  input  logic                                final_byte,
  // result output
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          plain_byte,
  output logic [msmd_pkg::POS_BITS-1:0]       byte_position,
  output logic                                chunk_done,
  // key registers
  input  logic                                cfg_write,
  input  logic [msmd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                         cfg_data
);

  // request between front and back
  logic                  front_push;
  msmd_pkg::cmd_t        front_cmd;
  msmd_pkg::cmd_t        q_cmd;
  logic                  q_empty;
  logic                  q_pop;
  msmd_pkg::res_t        res;
  msmd_pkg::back_status_t back_status;

  // front: counts offsets and classifies each byte
  msmd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .q_full         (full),
    .data_byte      (data_byte),
    .stream_kind    (stream_kind),
    .payload_length (payload_length),
    .final_byte     (final_byte),
    .cmd_push       (front_push),
    .cmd            (front_cmd)
  );

  // decouples classification from execution
  msmd_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .cmd_in  (front_cmd),
    .full    (full),
    .pop     (q_pop),
    .cmd_out (q_cmd),
    .empty   (q_empty)
  );

  // back: masks, hold buffer and result queue
  msmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res       (res),
    .res_empty (empty),
    .res_pop   (pop),
    .status    (back_status)
  );

  assign plain_byte    = res.data;
  assign byte_position = res.pos;
  assign chunk_done    = res.done;

  // nothing is waiting right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // the result queue never overfills
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.res_count <= msmd_pkg::RES_CNT_BITS'(msmd_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // a full request queue means the execute stage is occupied
  a_full_stage: assert property (@(posedge clk) disable iff (rst)
    full |-> back_status.stage_valid)
    else $error("request queue full while execute stage idle");

  // no result appears without a pending request or queued result
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (empty && !back_status.stage_valid) |=> empty)
    else $error("result appeared with nothing in flight");

endmodule
